### sv/wif_pkg.sv
// ============================================================================
// wif_pkg
// Shared types and constants of the washout IIR filter.
// ============================================================================
package wif_pkg;

  // Default widths of the sample path.
  localparam int SAMPLE_WIDTH_DEF  = 32;
  localparam int FRACTION_BITS_DEF = 16;

  // Register field widths.
  localparam int MODE_W   = 2;
  localparam int PERIOD_W = 10;
  localparam int CUTOFF_W = 24;
  localparam int DAMP_W   = 18;

  // The period is given in ms, so the cutoff product is scaled down by 1000.
  localparam int PERIOD_DIV = 1000;
  // floor(cutoff * period / 1000) fits in this many bits (1000 >= 2^9).
  localparam int TW_W = CUTOFF_W + PERIOD_W - 9;

  // Register reset values.
  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(10);
  localparam logic [CUTOFF_W-1:0] CUTOFF_RST = CUTOFF_W'(65536);
  localparam logic [DAMP_W-1:0]   DAMP_RST   = DAMP_W'(46341);

  // Filter selection.
  typedef enum logic [MODE_W-1:0] {
    MODE_TRANS = 2'd0,
    MODE_TILT  = 2'd1,
    MODE_ROT   = 2'd2,
    MODE_PASS  = 2'd3
  } mode_t;

  // Register map, one word per register.
  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_PERIOD = 2'd1,
    REG_CUTOFF = 2'd2,
    REG_DAMP   = 2'd3
  } reg_idx_t;

  // Command to the serial multiply-accumulate unit.
  typedef struct packed {
    logic start;
    logic clear;
    logic sub;
  } mac_cmd_t;

  // Command to the serial divider.
  typedef struct packed {
    logic start;
    logic round;
  } div_cmd_t;

endpackage

### sv/washout_iir_filter.sv
// ============================================================================
// washout_iir_filter
// Washout filter for a motion platform: second-order translation high-pass,
// damped tilt low-pass or first-order rotation high-pass in bilinear form,
// or pass-through.
// Usage:
//   The input channel takes one signed fixed-point sample per beat on
//   in_valid/in_ready; the result channel returns one filtered sample and a
//   saturation flag per beat on out_valid/out_ready. Registers (mode,
//   period, cutoff, damping) are written over the APB port; the user must
//   write them only while idle, as the block does not enforce it.
//   One sample is worked at a time. Each sample recomputes its coefficients
//   with a bit-serial multiply-accumulate unit and a bit-serial divider.
//   The next sample is taken once the result has gone to the output
//   register. Pass-through mode skips the coefficient and product steps
//   and passes the sample through unchanged.
//   in_ready is high only while the sequencer is idle.
//   The result sits in an output register; the next sample is accepted
//   while it waits, and its result is held back until the receiver has
//   taken the previous one.
//   Reset loads the register defaults and clears the input and output
//   histories.
// ============================================================================
module washout_iir_filter #(
  parameter int SAMPLE_WIDTH  = wif_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRACTION_BITS = wif_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_filtered,
  output logic                           out_saturated,
  // Register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  import wif_pkg::*;

  localparam int W  = SAMPLE_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int CW = F + 3;
  localparam int MB_A = (TW_W + 1 > CW) ? TW_W + 1 : CW;
  localparam int MB   = (MB_A > DAMP_W + 1) ? MB_A : DAMP_W + 1;
  localparam int DIT  = (TW_W > CW) ? TW_W : CW;
  localparam int D1 = 2 * TW_W - F;
  localparam int D2 = DAMP_W + TW_W - F + 2;
  localparam int D3 = F + 2;
  localparam int D4 = TW_W + 1;
  localparam int D12 = (D1 > D2) ? D1 : D2;
  localparam int D34 = (D3 > D4) ? D3 : D4;
  localparam int DEN_W = ((D12 > D34) ? D12 : D34) + 2;
  localparam int A1 = DEN_W + DIT + 1;
  localparam int A2 = W + CW + 4;
  localparam int A3 = 2 * F + 4;
  localparam int A12 = (A1 > A2) ? A1 : A2;
  localparam int ACC_W = (A12 > A3) ? A12 : A3;

  localparam logic signed [ACC_W-1:0] HALF     = ACC_W'(1) << (F - 1);
  localparam logic signed [ACC_W-1:0] TWO_ONE  = ACC_W'(1) << (F + 1);
  localparam logic signed [ACC_W-1:0] FOUR_ONE = ACC_W'(1) << (F + 2);
  localparam logic signed [ACC_W-1:0] NUM_R    = ACC_W'(1) << (2 * F + 1);
  localparam logic [DEN_W-1:0] TWO_ONE_D  = DEN_W'(1) << (F + 1);
  localparam logic [DEN_W-1:0] FOUR_ONE_D = DEN_W'(1) << (F + 2);
  localparam logic signed [ACC_W-1:0] MAXV =
    {{(ACC_W - W + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] MINV = ~MAXV;

  typedef enum logic [4:0] {
    S_IDLE, S_TWM, S_TWD, S_R, S_C, S_AM, S_AR, S_BM, S_BR,
    S_PM, S_PR, S_QM, S_QR, S_G, S_H1, S_H2,
    S_M0, S_M1, S_M2, S_RND, S_DONE
  } state_t;

  // Register file.
  mode_t               mode_r;
  logic [PERIOD_W-1:0] period_r;
  logic [CUTOFF_W-1:0] cutoff_r;
  logic [DAMP_W-1:0]   damp_r;

  state_t                  state_r;
  state_t                  state_nxt;
  logic                    mac_start_r;
  logic                    div_start_r;
  logic                    mac_go;
  logic                    div_go;
  logic [TW_W-1:0]         tw_r;
  logic [DEN_W-1:0]        p_r;
  logic [DEN_W-1:0]        q_r;
  logic signed [CW-1:0]    k0_r;
  logic signed [CW-1:0]    k1_r;
  logic signed [CW-1:0]    k2_r;
  logic signed [W-1:0]     x0_r;
  logic signed [W-1:0]     x1_r;
  logic signed [W-1:0]     x2_r;
  logic signed [W-1:0]     y1_r;
  logic signed [W-1:0]     y2_r;
  logic signed [ACC_W-1:0] y_full_r;
  logic                    out_valid_r;
  logic signed [W-1:0]     out_filtered_r;
  logic                    out_saturated_r;

  mac_cmd_t                mac_cmd;
  div_cmd_t                div_cmd;
  logic signed [ACC_W-1:0] mac_a;
  logic signed [MB-1:0]    mac_b;
  logic signed [ACC_W-1:0] mac_acc;
  logic                    mac_done;
  logic signed [ACC_W-1:0] div_num;
  logic [DEN_W-1:0]        div_den;
  logic                    div_round;
  logic signed [DIT:0]     div_q;
  logic                    div_done;

  logic signed [ACC_W-1:0] tw_s;
  logic signed [ACC_W-1:0] p_s;
  logic signed [ACC_W-1:0] q_s;
  logic [DEN_W-1:0]        d_val;
  logic [DEN_W-1:0]        e_val;
  logic signed [ACC_W-1:0] s_val;
  logic signed [ACC_W-1:0] y1m;
  logic signed [ACC_W-1:0] rnd_v;
  logic signed [W-1:0]     sat_y;
  logic                    sat_f;
  logic                    out_go;
  logic                    cfg_wr;

  // Round to FRACTION_BITS, nearest with ties away from zero.
  function automatic logic signed [ACC_W-1:0] rnd_f(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v + HALF - ACC_W'(v[ACC_W-1]);
    return t >>> F;
  endfunction

  // Register port: always ready, written on the access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_TRANS;
      period_r <= PERIOD_RST;
      cutoff_r <= CUTOFF_RST;
      damp_r   <= DAMP_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_MODE:   mode_r   <= mode_t'(pwdata[MODE_W-1:0]);
        REG_PERIOD: period_r <= pwdata[PERIOD_W-1:0];
        REG_CUTOFF: cutoff_r <= pwdata[CUTOFF_W-1:0];
        REG_DAMP:   damp_r   <= pwdata[DAMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    prdata = '0;
    unique case (reg_idx_t'(paddr[3:2]))
      REG_MODE:   prdata = 32'(mode_r);
      REG_PERIOD: prdata = 32'(period_r);
      REG_CUTOFF: prdata = 32'(cutoff_r);
      REG_DAMP:   prdata = 32'(damp_r);
      default:    prdata = '0;
    endcase
  end

  // Derived terms of the coefficient formulas.
  assign tw_s  = ACC_W'(tw_r);
  assign p_s   = ACC_W'(p_r);
  assign q_s   = ACC_W'(q_r);
  assign d_val = DEN_W'(tw_r) + TWO_ONE_D;
  assign e_val = p_r + q_r + FOUR_ONE_D;
  assign y1m   = (mode_r == MODE_TRANS) ? (ACC_W'(y1_r) <<< 1) : ACC_W'(y1_r);
  assign rnd_v = rnd_f(mac_acc);

  // Input combination of each filter.
  always_comb begin
    case (mode_r)
      MODE_TRANS: s_val = ACC_W'(x0_r) - (ACC_W'(x1_r) <<< 1) + ACC_W'(x2_r);
      MODE_TILT:  s_val = ACC_W'(x0_r) + (ACC_W'(x1_r) <<< 1) + ACC_W'(x2_r);
      default:    s_val = ACC_W'(x0_r) - ACC_W'(x1_r);
    endcase
  end

  // Operands of the serial units, chosen by sequencer step.
  always_comb begin
    mac_a     = '0;
    mac_b     = '0;
    div_num   = '0;
    div_den   = '0;
    div_round = 1'b1;
    unique case (state_r)
      S_TWM: begin
        mac_a = ACC_W'(cutoff_r);
        mac_b = MB'($signed({1'b0, period_r}));
      end
      S_TWD: begin
        div_num   = mac_acc;
        div_den   = DEN_W'(PERIOD_DIV);
        div_round = 1'b0;
      end
      S_R: begin
        div_num = NUM_R;
        div_den = d_val;
      end
      S_C: begin
        div_num = (tw_s - TWO_ONE) <<< F;
        div_den = d_val;
      end
      S_AM: begin
        mac_a = ACC_W'(k0_r);
        mac_b = MB'(k0_r);
      end
      S_BM: begin
        mac_a = ACC_W'(k1_r);
        mac_b = MB'(k1_r);
      end
      S_PM: begin
        mac_a = tw_s;
        mac_b = MB'($signed({1'b0, tw_r}));
      end
      S_QM: begin
        mac_a = tw_s <<< 2;
        mac_b = MB'($signed({1'b0, damp_r}));
      end
      S_G: begin
        div_num = p_s <<< F;
        div_den = e_val;
      end
      S_H1: begin
        div_num = (p_s - FOUR_ONE) <<< (F + 1);
        div_den = e_val;
      end
      S_H2: begin
        div_num = (p_s - q_s + FOUR_ONE) <<< F;
        div_den = e_val;
      end
      S_M0: begin
        mac_a = s_val;
        mac_b = MB'(k0_r);
      end
      S_M1: begin
        mac_a = y1m;
        mac_b = MB'(k1_r);
      end
      S_M2: begin
        mac_a = ACC_W'(y2_r);
        mac_b = MB'(k2_r);
      end
      default: ;
    endcase
  end

  assign mac_cmd.start = mac_start_r;
  assign mac_cmd.clear = !((state_r == S_M1) || (state_r == S_M2));
  assign mac_cmd.sub   = (state_r == S_M1) || (state_r == S_M2);
  assign div_cmd.start = div_start_r;
  assign div_cmd.round = div_round;

  wif_mac #(
    .ACC_W (ACC_W),
    .MB    (MB)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (mac_cmd),
    .a_in   (mac_a),
    .b_in   (mac_b),
    .acc_o  (mac_acc),
    .done_o (mac_done)
  );

  wif_div #(
    .ACC_W (ACC_W),
    .DEN_W (DEN_W),
    .DIT   (DIT)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (div_cmd),
    .num    (div_num),
    .den    (div_den),
    .q_o    (div_q),
    .done_o (div_done)
  );

  // Saturation of the rounded result.
  always_comb begin
    sat_f = 1'b0;
    sat_y = y_full_r[W-1:0];
    if (y_full_r > MAXV) begin
      sat_f = 1'b1;
      sat_y = MAXV[W-1:0];
    end else if (y_full_r < MINV) begin
      sat_f = 1'b1;
      sat_y = MINV[W-1:0];
    end
  end

  assign out_go   = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == S_IDLE);

  // Sequencer next step.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = (mode_r == MODE_PASS) ? S_DONE : S_TWM;
      S_TWM:  if (mac_done) state_nxt = S_TWD;
      S_TWD:  if (div_done) state_nxt = (mode_r == MODE_TILT) ? S_PM : S_R;
      S_R:    if (div_done) state_nxt = S_C;
      S_C:    if (div_done) state_nxt = (mode_r == MODE_TRANS) ? S_AM : S_M0;
      S_AM:   if (mac_done) state_nxt = S_AR;
      S_AR:   state_nxt = S_BM;
      S_BM:   if (mac_done) state_nxt = S_BR;
      S_BR:   state_nxt = S_M0;
      S_PM:   if (mac_done) state_nxt = S_PR;
      S_PR:   state_nxt = S_QM;
      S_QM:   if (mac_done) state_nxt = S_QR;
      S_QR:   state_nxt = S_G;
      S_G:    if (div_done) state_nxt = S_H1;
      S_H1:   if (div_done) state_nxt = S_H2;
      S_H2:   if (div_done) state_nxt = S_M0;
      S_M0:   if (mac_done) state_nxt = S_M1;
      S_M1:   if (mac_done) state_nxt = S_M2;
      S_M2:   if (mac_done) state_nxt = S_RND;
      S_RND:  state_nxt = S_DONE;
      S_DONE: if (out_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // A unit is started on entry into one of its steps.
  always_comb begin
    mac_go = 1'b0;
    div_go = 1'b0;
    unique case (state_nxt) inside
      S_TWM, S_AM, S_BM, S_PM, S_QM, S_M0, S_M1, S_M2: mac_go = 1'b1;
      S_TWD, S_R, S_C, S_G, S_H1, S_H2:                div_go = 1'b1;
      default: ;
    endcase
  end

  // Sequencer state, unit starts, coefficients, histories and output beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mac_start_r <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      x1_r        <= '0;
      x2_r        <= '0;
      y1_r        <= '0;
      y2_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      mac_start_r <= mac_go && (state_nxt != state_r);
      div_start_r <= div_go && (state_nxt != state_r);

      if ((state_r == S_IDLE) && in_valid) begin
        x0_r     <= in_sample;
        y_full_r <= ACC_W'(in_sample);
      end

      if (div_done) begin
        unique case (state_r) inside
          S_TWD: tw_r <= div_q[TW_W-1:0];
          S_R, S_G: k0_r <= div_q[CW-1:0];
          S_C: begin
            k1_r <= div_q[CW-1:0];
            k2_r <= '0;
          end
          S_H1: k1_r <= div_q[CW-1:0];
          S_H2: k2_r <= div_q[CW-1:0];
          default: ;
        endcase
      end

      unique case (state_r) inside
        S_AR:  k0_r     <= rnd_v[CW-1:0];
        S_BR:  k2_r     <= rnd_v[CW-1:0];
        S_PR:  p_r      <= rnd_v[DEN_W-1:0];
        S_QR:  q_r      <= rnd_v[DEN_W-1:0];
        S_RND: y_full_r <= rnd_v;
        default: ;
      endcase

      if (out_go) begin
        out_valid_r     <= 1'b1;
        out_filtered_r  <= sat_y;
        out_saturated_r <= sat_f;
        x2_r            <= x1_r;
        x1_r            <= x0_r;
        y2_r            <= y1_r;
        y1_r            <= sat_y;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_filtered  = out_filtered_r;
  assign out_saturated = out_saturated_r;

endmodule

### sv/wif_mac.sv
// ============================================================================
// wif_mac
// Bit-serial multiply-accumulate: one multiplier bit per cycle, LSB first.
// ============================================================================
module wif_mac #(
  parameter int ACC_W = 62,
  parameter int MB    = 26
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  wif_pkg::mac_cmd_t       cmd,
  input  logic signed [ACC_W-1:0] a_in,
  input  logic signed [MB-1:0]    b_in,
  output logic signed [ACC_W-1:0] acc_o,
  output logic                    done_o
);

  localparam int CNT_W = (MB > 1) ? $clog2(MB) : 1;

  logic signed [ACC_W-1:0] a_r;
  logic signed [MB-1:0]    b_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W-1:0] term;
  logic [CNT_W-1:0]        cnt_r;
  logic                    busy_r;
  logic                    sub_r;
  logic                    done_r;
  logic                    last;
  logic                    neg;

  // The top multiplier bit carries negative weight, so it flips the sign.
  assign last    = (cnt_r == CNT_W'(MB - 1));
  assign term    = b_r[0] ? a_r : '0;
  assign neg     = sub_r ^ last;
  assign acc_nxt = neg ? (acc_r - term) : (acc_r + term);

  // Control and datapath of the shift-add loop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        a_r    <= a_in;
        b_r    <= b_in;
        sub_r  <= cmd.sub;
        if (cmd.clear) begin
          acc_r <= '0;
        end
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        a_r   <= a_r <<< 1;
        b_r   <= b_r >>> 1;
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign acc_o  = acc_r;
  assign done_o = done_r;

endmodule

### sv/wif_div.sv
// ============================================================================
// wif_div
// Restoring divider, one quotient bit per cycle, with optional rounding to
// nearest (ties away from zero) on a signed numerator.
// ============================================================================
module wif_div #(
  parameter int ACC_W = 62,
  parameter int DEN_W = 36,
  parameter int DIT   = 25
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  wif_pkg::div_cmd_t       cmd,
  input  logic signed [ACC_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic signed [DIT:0]     q_o,
  output logic                    done_o
);

  localparam int CNT_W = $clog2(DIT);

  typedef enum logic [1:0] {
    D_IDLE,
    D_ABS,
    D_HALF,
    D_ITER
  } dstate_t;

  dstate_t          state_r;
  logic [ACC_W-1:0] rem_r;
  logic [ACC_W-1:0] dsh_r;
  logic [DEN_W-1:0] den_r;
  logic [DIT-1:0]   q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r;
  logic             round_r;
  logic             done_r;
  logic             ge;

  assign ge = (rem_r >= dsh_r);

  // Magnitude, rounding offset, then one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (cmd.start) begin
            rem_r   <= num;
            neg_r   <= num[ACC_W-1];
            den_r   <= den;
            round_r <= cmd.round;
            state_r <= D_ABS;
          end
        end
        D_ABS: begin
          rem_r   <= neg_r ? (~rem_r + 1'b1) : rem_r;
          state_r <= D_HALF;
        end
        D_HALF: begin
          rem_r   <= rem_r + (round_r ? ACC_W'(den_r >> 1) : '0);
          dsh_r   <= ACC_W'(den_r) << (DIT - 1);
          q_r     <= '0;
          cnt_r   <= '0;
          state_r <= D_ITER;
        end
        D_ITER: begin
          if (ge) begin
            rem_r <= rem_r - dsh_r;
          end
          q_r   <= {q_r[DIT-2:0], ge};
          dsh_r <= dsh_r >> 1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(DIT - 1)) begin
            done_r  <= 1'b1;
            state_r <= D_IDLE;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign q_o    = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  assign done_o = done_r;

endmodule
